[src/assert_macros.svh]
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is asserted.
`define SDR_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also runs during reset.
`define SDR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/sdr_pkg.sv]
// ----------------------------------------------------------------------------
// sdr_pkg
// Shared codes and constants of the stream-aware replacement engine.
// ----------------------------------------------------------------------------
package sdr_pkg;

    localparam logic CMD_VICTIM = 1'b0;
    localparam logic CMD_UPDATE = 1'b1;

    localparam logic CFG_STREAM_THR = 1'b0;
    localparam logic CFG_REUSE_THR  = 1'b1;

    localparam logic [1:0] RRPV_NEAR    = 2'd0;
    localparam logic [1:0] RRPV_STATIC  = 2'd2;
    localparam logic [1:0] RRPV_DISTANT = 2'd3;

    localparam logic [1:0] SIGN_ZERO = 2'd0;
    localparam logic [1:0] SIGN_POS  = 2'd1;
    localparam logic [1:0] SIGN_NEG  = 2'd2;

    localparam logic [1:0] CTR_MAX   = 2'd3;
    localparam logic [1:0] CTR_RESET = 2'd1;

    localparam int PC_SHIFT     = 7;
    localparam int BIMODAL_BITS = 5;
    localparam int OUT_WAY_BITS = 4;

    localparam logic [2:0] STREAM_THR_RESET = 3'd3;
    localparam logic [1:0] REUSE_THR_RESET  = 2'd1;

endpackage

[src/sdr_ram.sv]
// ----------------------------------------------------------------------------
// sdr_ram
// Generic simple dual-port RAM with registered read.
// ----------------------------------------------------------------------------
module sdr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

[src/sdr_front.sv]
// ----------------------------------------------------------------------------
// sdr_front
// Accepts transactions, folds indexes, hashes the PC, tags leader sets and
// queues the result in a two-entry FIFO for the back end.
// ----------------------------------------------------------------------------
module sdr_front #(
    parameter int NUM_SETS           = 2048,
    parameter int NUM_WAYS           = 16,
    parameter int LEADERS_PER_POLICY = 64,
    parameter int SIGNATURE_BITS     = 5
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_cmd,
    input  logic [10:0]                   i_set_index,
    input  logic [3:0]                    i_way_index,
    input  logic [63:0]                   i_phys_address,
    input  logic [63:0]                   i_prog_counter,
    input  logic                          i_is_hit,
    output logic                          o_q_valid,
    input  logic                          i_q_pop,
    output logic                          o_q_cmd,
    output logic [$clog2(NUM_SETS)-1:0]   o_q_set,
    output logic [$clog2(NUM_WAYS)-1:0]   o_q_way,
    output logic [63:0]                   o_q_addr,
    output logic [SIGNATURE_BITS-1:0]     o_q_sig,
    output logic                          o_q_hit,
    output logic                          o_q_lead_static,
    output logic                          o_q_lead_bimodal
);
    localparam int SW = $clog2(NUM_SETS);
    localparam int WW = $clog2(NUM_WAYS);
    localparam int EW = 1 + SW + WW + 64 + SIGNATURE_BITS + 3;

    logic [SW-1:0]             set_f;
    logic [WW-1:0]             way_f;
    logic [SIGNATURE_BITS-1:0] sig;
    logic                      lead_s;
    logic                      lead_b;
    logic [EW-1:0]             entry;
    logic [EW-1:0]             r_q [2];
    logic                      r_wp;
    logic                      r_rp;
    logic [1:0]                r_cnt;
    logic                      push;

    assign set_f  = SW'(i_set_index % NUM_SETS);
    assign way_f  = WW'(i_way_index % NUM_WAYS);
    assign sig    = SIGNATURE_BITS'(i_prog_counter ^ (i_prog_counter >> sdr_pkg::PC_SHIFT));
    assign lead_s = 32'(set_f) < 32'(LEADERS_PER_POLICY);
    assign lead_b = (LEADERS_PER_POLICY >= NUM_SETS) ||
                    (32'(set_f) >= 32'(NUM_SETS - LEADERS_PER_POLICY));
    assign entry  = {i_cmd, set_f, way_f, i_phys_address, sig, i_is_hit, lead_s, lead_b};

    assign o_in_stall = (r_cnt == 2'd2);
    assign push       = i_in_valid && !o_in_stall;
    assign o_q_valid  = (r_cnt != 2'd0);

    assign {o_q_cmd, o_q_set, o_q_way, o_q_addr, o_q_sig, o_q_hit,
            o_q_lead_static, o_q_lead_bimodal} = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (i_q_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(i_q_pop);
        end
    end
endmodule

[src/sdr_back.sv]
// ----------------------------------------------------------------------------
// sdr_back
// Read-modify-write of the per-set row: victim scan and aging, stream
// detector, hit promotion and miss insertion with set dueling.
// ----------------------------------------------------------------------------
module sdr_back #(
    parameter int NUM_SETS       = 2048,
    parameter int NUM_WAYS       = 16,
    parameter int SIGNATURE_BITS = 5,
    parameter int HISTORY_DEPTH  = 4,
    parameter int SELECTOR_BITS  = 10
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_index,
    input  logic [2:0]                  i_cfg_data,
    input  logic                        i_q_valid,
    output logic                        o_q_pop,
    input  logic                        i_q_cmd,
    input  logic [$clog2(NUM_SETS)-1:0] i_q_set,
    input  logic [$clog2(NUM_WAYS)-1:0] i_q_way,
    input  logic [63:0]                 i_q_addr,
    input  logic [SIGNATURE_BITS-1:0]   i_q_sig,
    input  logic                        i_q_hit,
    input  logic                        i_q_lead_static,
    input  logic                        i_q_lead_bimodal,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [3:0]                  o_victim_way,
    output logic                        o_set_streaming,
    output logic [1:0]                  o_written_rrpv
);
    localparam int SW    = $clog2(NUM_SETS);
    localparam int WW    = $clog2(NUM_WAYS);
    localparam int SB    = SIGNATURE_BITS;
    localparam int HD    = HISTORY_DEPTH;
    localparam int PW    = $clog2(HD);
    localparam int CW    = $clog2(HD + 1);
    localparam int MW    = (CW > 3) ? CW : 3;
    localparam int NCTR  = 1 << SB;
    localparam int O_HST = PW;
    localparam int O_LST = O_HST + 2 * HD;
    localparam int O_SIG = O_LST + 64;
    localparam int O_RRP = O_SIG + NUM_WAYS * SB;
    localparam int RW    = O_RRP + 2 * NUM_WAYS;
    localparam logic [SELECTOR_BITS-1:0] SEL_MAX  = {SELECTOR_BITS{1'b1}};
    localparam logic [SELECTOR_BITS-1:0] SEL_HALF = SEL_MAX >> 1;
    localparam int BIMODAL_BITS_W = sdr_pkg::BIMODAL_BITS;

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_EXEC  = 2'd2;

    logic [1:0]                r_state;
    logic [1:0]                n_state;
    logic [SW-1:0]             r_clr;
    logic [2:0]                r_stream_thr;
    logic [1:0]                r_reuse_thr;
    logic [SELECTOR_BITS-1:0]  r_sel;
    logic [SELECTOR_BITS-1:0]  n_sel;
    logic [BIMODAL_BITS_W-1:0] r_bc;
    logic [BIMODAL_BITS_W-1:0] n_bc;
    logic [1:0]                r_ctr [NCTR];
    logic                      r_cmd, r_hit, r_ls, r_lb;
    logic [SW-1:0]             r_set;
    logic [WW-1:0]             r_way;
    logic [63:0]               r_addr;
    logic [SB-1:0]             r_sig;
    logic                      r_out_valid;
    logic [3:0]                r_victim_way;
    logic                      r_set_streaming;
    logic [1:0]                r_written_rrpv;

    logic [RW-1:0]        rdata, wdata, clr_row;
    logic                 we, re;
    logic [SW-1:0]        waddr;
    logic                 out_free, exec;
    logic [2*NUM_WAYS-1:0]  rrpv_row, rrpv_aged, rrpv_new;
    logic [NUM_WAYS*SB-1:0] sig_row, sig_new;
    logic [63:0]          last;
    logic [2*HD-1:0]      hist, hist_new;
    logic [PW-1:0]        ptr, ptr_new;
    logic                 any3, any2;
    logic [WW-1:0]        first3, first2, vict;
    logic [63:0]          delta;
    logic                 last_nz;
    logic [1:0]           sgn;
    logic [CW-1:0]        n_pos, n_neg, n_nz;
    logic                 streaming;
    logic [SB-1:0]        way_ls, ctr_addr;
    logic [1:0]           ctr_val, ctr_new;
    logic                 ctr_we;
    logic                 bimodal;
    logic [BIMODAL_BITS_W-1:0] bc_inc;
    logic [1:0]           ins;
    logic [SELECTOR_BITS-1:0]  sel_up;

    sdr_ram #(.WIDTH(RW), .DEPTH(NUM_SETS)) u_row_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_re   (re),
        .i_raddr(i_q_set),
        .o_rdata(rdata)
    );

    // reset row: every RRPV distant, everything else zero
    always_comb begin
        clr_row = '0;
        for (int w = 0; w < NUM_WAYS; w++) begin
            clr_row[O_RRP + 2*w +: 2] = sdr_pkg::RRPV_DISTANT;
        end
    end

    assign out_free = !r_out_valid || !i_out_stall;
    assign exec     = (r_state == ST_EXEC) && out_free;
    assign re       = (r_state == ST_IDLE) && i_q_valid;
    assign o_q_pop  = re;

    assign ptr      = rdata[PW-1:0];
    assign hist     = rdata[O_HST +: 2*HD];
    assign last     = rdata[O_LST +: 64];
    assign sig_row  = rdata[O_SIG +: NUM_WAYS*SB];
    assign rrpv_row = rdata[O_RRP +: 2*NUM_WAYS];

    // victim scan and aging
    always_comb begin
        any3 = 1'b0; any2 = 1'b0;
        first3 = '0; first2 = '0;
        for (int w = NUM_WAYS - 1; w >= 0; w--) begin
            if (rrpv_row[2*w +: 2] == sdr_pkg::RRPV_DISTANT) begin
                any3 = 1'b1; first3 = WW'(w);
            end
            if (rrpv_row[2*w +: 2] == sdr_pkg::RRPV_STATIC) begin
                any2 = 1'b1; first2 = WW'(w);
            end
        end
        for (int w = 0; w < NUM_WAYS; w++) begin
            rrpv_aged[2*w +: 2] = (rrpv_row[2*w +: 2] == sdr_pkg::RRPV_DISTANT) ?
                                  sdr_pkg::RRPV_DISTANT : rrpv_row[2*w +: 2] + 2'd1;
        end
        vict = any3 ? first3 : (any2 ? first2 : '0);
    end

    // stream detector
    always_comb begin
        delta   = r_addr - last;
        last_nz = (last != 64'd0);
        sgn     = (delta == 64'd0) ? sdr_pkg::SIGN_ZERO :
                  (delta[63] ? sdr_pkg::SIGN_NEG : sdr_pkg::SIGN_POS);
        hist_new = hist;
        ptr_new  = ptr;
        if (last_nz) begin
            hist_new[2*ptr +: 2] = sgn;
            ptr_new = (32'(ptr) == HD - 1) ? '0 : ptr + PW'(1);
        end
        n_pos = '0; n_neg = '0; n_nz = '0;
        for (int i = 0; i < HD; i++) begin
            if (hist_new[2*i +: 2] == sdr_pkg::SIGN_POS) n_pos = n_pos + CW'(1);
            if (hist_new[2*i +: 2] == sdr_pkg::SIGN_NEG) n_neg = n_neg + CW'(1);
            if (hist_new[2*i +: 2] != sdr_pkg::SIGN_ZERO) n_nz = n_nz + CW'(1);
        end
        streaming = (MW'(n_nz) >= MW'(r_stream_thr)) &&
                    ((MW'(n_pos) >= MW'(r_stream_thr)) || (MW'(n_neg) >= MW'(r_stream_thr)));
    end

    // update path
    always_comb begin
        way_ls   = sig_row[r_way*SB +: SB];
        ctr_addr = (r_hit && !streaming) ? way_ls : r_sig;
        ctr_val  = r_ctr[ctr_addr];
        bimodal  = r_lb || (!r_ls && (r_sel < SEL_HALF));
        bc_inc   = r_bc + BIMODAL_BITS_W'(1);
        ins      = bimodal ? ((bc_inc == '0) ? sdr_pkg::RRPV_NEAR : sdr_pkg::RRPV_DISTANT)
                           : sdr_pkg::RRPV_STATIC;
        if (ctr_val > r_reuse_thr) ins = sdr_pkg::RRPV_NEAR;
        sel_up   = (r_ls && (r_sel != SEL_MAX)) ? r_sel + SELECTOR_BITS'(1) : r_sel;

        rrpv_new = rrpv_row;
        sig_new  = sig_row;
        n_sel    = r_sel;
        n_bc     = r_bc;
        ctr_new  = ctr_val;
        ctr_we   = 1'b0;
        if (streaming) begin
            rrpv_new[2*r_way +: 2] = sdr_pkg::RRPV_DISTANT;
            sig_new[r_way*SB +: SB] = r_sig;
        end else if (r_hit) begin
            rrpv_new[2*r_way +: 2] = sdr_pkg::RRPV_NEAR;
            ctr_we  = 1'b1;
            ctr_new = (ctr_val != sdr_pkg::CTR_MAX) ? ctr_val + 2'd1 : ctr_val;
            n_sel   = (r_lb && (sel_up != '0)) ? sel_up - SELECTOR_BITS'(1) : sel_up;
        end else begin
            sig_new[r_way*SB +: SB] = r_sig;
            rrpv_new[2*r_way +: 2] = ins;
            if (bimodal) n_bc = bc_inc;
            ctr_we  = 1'b1;
            ctr_new = (ctr_val != 2'd0) ? ctr_val - 2'd1 : ctr_val;
        end
    end

    always_comb begin
        if (r_state == ST_CLEAR) begin
            we    = 1'b1;
            waddr = r_clr;
            wdata = clr_row;
        end else begin
            we    = exec;
            waddr = r_set;
            if (r_cmd == sdr_pkg::CMD_VICTIM) begin
                wdata = rdata;
                wdata[O_RRP +: 2*NUM_WAYS] = any3 ? rrpv_row : rrpv_aged;
            end else begin
                wdata = {rrpv_new, sig_new, r_addr, hist_new, ptr_new};
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: if (r_clr == SW'(NUM_SETS - 1)) n_state = ST_IDLE;
            ST_IDLE:  if (i_q_valid) n_state = ST_EXEC;
            ST_EXEC:  if (out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (re) begin
            r_cmd  <= i_q_cmd;
            r_set  <= i_q_set;
            r_way  <= i_q_way;
            r_addr <= i_q_addr;
            r_sig  <= i_q_sig;
            r_hit  <= i_q_hit;
            r_ls   <= i_q_lead_static;
            r_lb   <= i_q_lead_bimodal;
        end
        if (exec) begin
            if (r_cmd == sdr_pkg::CMD_VICTIM) begin
                r_victim_way    <= sdr_pkg::OUT_WAY_BITS'(vict);
                r_set_streaming <= 1'b0;
                r_written_rrpv  <= 2'd0;
            end else begin
                r_victim_way    <= '0;
                r_set_streaming <= streaming;
                r_written_rrpv  <= streaming ? sdr_pkg::RRPV_DISTANT :
                                   (r_hit ? sdr_pkg::RRPV_NEAR : ins);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_clr        <= '0;
            r_stream_thr <= sdr_pkg::STREAM_THR_RESET;
            r_reuse_thr  <= sdr_pkg::REUSE_THR_RESET;
            r_sel        <= SEL_HALF;
            r_bc         <= '0;
            r_out_valid  <= 1'b0;
            for (int i = 0; i < NCTR; i++) r_ctr[i] <= sdr_pkg::CTR_RESET;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) r_clr <= r_clr + SW'(1);
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    sdr_pkg::CFG_STREAM_THR: r_stream_thr <= i_cfg_data;
                    sdr_pkg::CFG_REUSE_THR:  r_reuse_thr  <= i_cfg_data[1:0];
                    default: ;
                endcase
            end
            if (exec) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (exec && (r_cmd == sdr_pkg::CMD_UPDATE)) begin
                r_sel <= n_sel;
                r_bc  <= n_bc;
                if (ctr_we) r_ctr[ctr_addr] <= ctr_new;
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_victim_way    = r_victim_way;
    assign o_set_streaming = r_set_streaming;
    assign o_written_rrpv  = r_written_rrpv;
endmodule

[src/ship_drrip_stream_bypass_replacement_core.sv]
// ----------------------------------------------------------------------------
// ship_drrip_stream_bypass_replacement_core
// Last-level cache replacement engine with signature reuse, set dueling
// and a per-set stream detector.
// ----------------------------------------------------------------------------
// Each transaction reads the set's row (RRPVs, line signatures, stream
// state) from a single RAM in ST_IDLE, then in ST_EXEC, which waits while
// the output is stalled, modifies and writes it back while the result is
// loaded into the output register. A two-entry queue in front lets new
// transactions land while the back end works or the output is stalled.
// After reset the row RAM is swept once before the first transaction
// executes; transactions may queue meanwhile. Config writes take effect
// at once and are expected only while the engine is idle.
module ship_drrip_stream_bypass_replacement_core #(
    parameter int NUM_SETS           = 2048,
    parameter int NUM_WAYS           = 16,
    parameter int LEADERS_PER_POLICY = 64,
    parameter int SIGNATURE_BITS     = 5,
    parameter int HISTORY_DEPTH      = 4,
    parameter int SELECTOR_BITS      = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [2:0]  i_cfg_data,
    // request channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_cmd,
    input  logic [10:0] i_set_index,
    input  logic [3:0]  i_way_index,
    input  logic [63:0] i_phys_address,
    input  logic [63:0] i_prog_counter,
    input  logic        i_is_hit,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [3:0]  o_victim_way,
    output logic        o_set_streaming,
    output logic [1:0]  o_written_rrpv
);
    localparam int SW = $clog2(NUM_SETS);
    localparam int WW = $clog2(NUM_WAYS);

    // front-to-back queue head
    logic                      q_valid, q_pop, q_cmd, q_hit, q_ls, q_lb;
    logic [SW-1:0]             q_set;
    logic [WW-1:0]             q_way;
    logic [63:0]               q_addr;
    logic [SIGNATURE_BITS-1:0] q_sig;

    sdr_front #(
        .NUM_SETS          (NUM_SETS),
        .NUM_WAYS          (NUM_WAYS),
        .LEADERS_PER_POLICY(LEADERS_PER_POLICY),
        .SIGNATURE_BITS    (SIGNATURE_BITS)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_cmd           (i_cmd),
        .i_set_index     (i_set_index),
        .i_way_index     (i_way_index),
        .i_phys_address  (i_phys_address),
        .i_prog_counter  (i_prog_counter),
        .i_is_hit        (i_is_hit),
        .o_q_valid       (q_valid),
        .i_q_pop         (q_pop),
        .o_q_cmd         (q_cmd),
        .o_q_set         (q_set),
        .o_q_way         (q_way),
        .o_q_addr        (q_addr),
        .o_q_sig         (q_sig),
        .o_q_hit         (q_hit),
        .o_q_lead_static (q_ls),
        .o_q_lead_bimodal(q_lb)
    );

    sdr_back #(
        .NUM_SETS      (NUM_SETS),
        .NUM_WAYS      (NUM_WAYS),
        .SIGNATURE_BITS(SIGNATURE_BITS),
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .SELECTOR_BITS (SELECTOR_BITS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_q_valid       (q_valid),
        .o_q_pop         (q_pop),
        .i_q_cmd         (q_cmd),
        .i_q_set         (q_set),
        .i_q_way         (q_way),
        .i_q_addr        (q_addr),
        .i_q_sig         (q_sig),
        .i_q_hit         (q_hit),
        .i_q_lead_static (q_ls),
        .i_q_lead_bimodal(q_lb),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_victim_way    (o_victim_way),
        .o_set_streaming (o_set_streaming),
        .o_written_rrpv  (o_written_rrpv)
    );
endmodule

[src/sdr_checker.sv]
// ----------------------------------------------------------------------------
// sdr_checker
// Port-level checks of the replacement engine, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sdr_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [3:0] o_victim_way,
    input logic       o_set_streaming,
    input logic [1:0] o_written_rrpv
);
    `SDR_ASSERT_ALWAYS(a_rst_idle, i_clk, !i_rst_n |=> !o_out_valid, "output valid after reset")
    `SDR_ASSERT(a_hold, i_clk, i_rst_n, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_victim_way) && $stable(o_written_rrpv), "stalled result changed")
    `SDR_ASSERT(a_stream_rrpv, i_clk, i_rst_n, o_out_valid && o_set_streaming |-> o_written_rrpv == sdr_pkg::RRPV_DISTANT, "streaming result not distant")
    `SDR_ASSERT(a_victim_excl, i_clk, i_rst_n, o_out_valid && (o_victim_way != 4'd0) |-> !o_set_streaming && (o_written_rrpv == sdr_pkg::RRPV_NEAR), "victim result carries update fields")
endmodule

bind ship_drrip_stream_bypass_replacement_core sdr_checker u_sdr_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_victim_way   (o_victim_way),
    .o_set_streaming(o_set_streaming),
    .o_written_rrpv (o_written_rrpv)
);
